[rtl/assert_macros.svh]
// assertion macros used by the checker file
// depends on nothing; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define CHK_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// implication checked at every clock edge outside reset
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/rgbc_pkg.sv]
// shared types and constants of the rgbc to hsl converter
// no dependencies; imported by the converter, its divider and its checker
`default_nettype none

package rgbc_pkg;

  // depth of the valid and zero-clear pipelines
  localparam int LATENCY     = 19;
  // quotient bits of every divider (covers 0..100)
  localparam int DIV_Q       = 7;

  localparam logic [6:0] PCT_FULL    = 7'd100;
  localparam logic [6:0] NORM_LIMIT  = 7'd101;
  localparam logic [6:0] HALF_LIGHT  = 7'd50;
  localparam logic [7:0] SUM_FULL    = 8'd200;
  localparam logic [5:0] HUE_SECTOR  = 6'd60;
  localparam logic [8:0] HUE_RED     = 9'd0;
  localparam logic [8:0] HUE_GREEN   = 9'd120;
  localparam logic [8:0] HUE_BLUE    = 9'd240;
  localparam logic [8:0] HUE_WRAP    = 9'd360;

  // side information carried alongside the hue and saturation dividers
  typedef struct packed {
    logic       gray;     // max equals min
    logic       neg;      // hue term is subtracted from base
    logic [8:0] base;     // hue sector base in degrees
    logic [6:0] light;    // lightness percent
  } hue_side_t;

endpackage

`default_nettype wire

[rtl/rgbc_to_hsl_converter.sv]
// top level of the rgbc to hsl converter
// uses rgbc_pkg and rgbc_div
//
// usage:
//   a transaction enters when start is high and busy is low; busy is never
//   raised, so one transaction may enter in every cycle
//   clear_count, red_count, green_count and blue_count are sampled then
//   hue, saturation, lightness and zero_clear appear for exactly one cycle
//   with done high, in entry order
//   throughput is one transaction per cycle; the pipeline is made of two chains
//   of seven single-bit divider stages (color normalization, then hue and
//   saturation) plus five register stages around them
//   a zero clear count raises zero_clear and gives zero hue, saturation
//   and lightness
//   reset clears the valid pipeline, so nothing in flight is delivered
//   the receiver cannot stall; results are not held past their cycle
`default_nettype none

module rgbc_to_hsl_converter
  import rgbc_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [COUNT_BITS-1:0] clear_count,
  input  logic [COUNT_BITS-1:0] red_count,
  input  logic [COUNT_BITS-1:0] green_count,
  input  logic [COUNT_BITS-1:0] blue_count,
  output logic                  done,
  output logic [8:0]            hue,
  output logic [6:0]            saturation,
  output logic [6:0]            lightness,
  output logic                  zero_clear
);

  localparam int PW = COUNT_BITS + 7;

  logic [LATENCY-1:0]    vld;
  logic [LATENCY-1:0]    zc;
  logic [COUNT_BITS-1:0] c0, r0, g0, b0;
  logic [PW-1:0]         pr1, pg1, pb1, lim1;
  logic [COUNT_BITS-1:0] c1;
  logic [2:0]            sat_sr [DIV_Q];
  logic [DIV_Q-1:0]      qr, qg, qb;
  logic [6:0]            r9, g9, b9;
  logic [12:0]           hnum_next, hnum;
  logic [6:0]            hden_next, hden;
  logic [13:0]           snum_next, snum;
  logic [7:0]            sden_next, sden;
  hue_side_t             side_next, side;
  hue_side_t             side_sr [DIV_Q];
  logic [DIV_Q-1:0]      hq, sq;
  logic [8:0]            hue_next;
  logic [6:0]            sat_next, light_next;

  assign busy = 1'b0;
  assign done = vld[LATENCY-1];

  // valid and zero-clear flags travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LATENCY-2:0], start & ~busy};
    end
  end

  always_ff @(posedge clk) begin
    zc <= {zc[LATENCY-2:0], clear_count == '0};
  end

  // input capture, then percentage numerators and saturation limit
  always_ff @(posedge clk) begin
    c0   <= clear_count;
    r0   <= red_count;
    g0   <= green_count;
    b0   <= blue_count;
    pr1  <= PW'(r0) * PW'(PCT_FULL);
    pg1  <= PW'(g0) * PW'(PCT_FULL);
    pb1  <= PW'(b0) * PW'(PCT_FULL);
    lim1 <= PW'(c0) * PW'(NORM_LIMIT);
    c1   <= c0;
  end

  // saturation flags wait for the normalization quotients
  always_ff @(posedge clk) begin
    sat_sr[0] <= {pr1 >= lim1, pg1 >= lim1, pb1 >= lim1};
    for (int k = 1; k < DIV_Q; k++) begin
      sat_sr[k] <= sat_sr[k-1];
    end
  end

  rgbc_div #(.NW(PW), .DW(COUNT_BITS), .QW(DIV_Q)) u_div_r (
    .clk(clk), .num(pr1), .den(c1), .quo(qr)
  );
  rgbc_div #(.NW(PW), .DW(COUNT_BITS), .QW(DIV_Q)) u_div_g (
    .clk(clk), .num(pg1), .den(c1), .quo(qg)
  );
  rgbc_div #(.NW(PW), .DW(COUNT_BITS), .QW(DIV_Q)) u_div_b (
    .clk(clk), .num(pb1), .den(c1), .quo(qb)
  );

  // clamped color percentages
  always_ff @(posedge clk) begin
    r9 <= sat_sr[DIV_Q-1][2] ? PCT_FULL : qr;
    g9 <= sat_sr[DIV_Q-1][1] ? PCT_FULL : qg;
    b9 <= sat_sr[DIV_Q-1][0] ? PCT_FULL : qb;
  end

  // max, min, lightness and divider operands for hue and saturation
  always_comb begin
    logic [6:0] mx, mn, dif, ta, tb, mag;
    logic [7:0] sum;
    mx = r9;
    if (g9 > mx) mx = g9;
    if (b9 > mx) mx = b9;
    mn = r9;
    if (g9 < mn) mn = g9;
    if (b9 < mn) mn = b9;
    dif = mx - mn;
    sum = {1'b0, mx} + {1'b0, mn};
    side_next.light = sum[7:1];
    side_next.gray  = (dif == '0);
    if (mx == r9) begin
      ta = g9;
      tb = b9;
      side_next.base = (g9 >= b9) ? HUE_RED : HUE_WRAP;
    end else if (mx == g9) begin
      ta = b9;
      tb = r9;
      side_next.base = HUE_GREEN;
    end else begin
      ta = r9;
      tb = g9;
      side_next.base = HUE_BLUE;
    end
    side_next.neg = (ta < tb);
    mag = side_next.neg ? (tb - ta) : (ta - tb);
    hnum_next = 13'(mag) * 13'(HUE_SECTOR);
    hden_next = side_next.gray ? 7'd1 : dif;
    snum_next = 14'(dif) * 14'(PCT_FULL);
    if (side_next.gray) begin
      sden_next = 8'd1;
    end else if (side_next.light <= HALF_LIGHT) begin
      sden_next = sum;
    end else begin
      sden_next = SUM_FULL - sum;
    end
  end

  always_ff @(posedge clk) begin
    hnum <= hnum_next;
    hden <= hden_next;
    snum <= snum_next;
    sden <= sden_next;
    side <= side_next;
  end

  // side information waits for the hue and saturation quotients
  always_ff @(posedge clk) begin
    side_sr[0] <= side;
    for (int k = 1; k < DIV_Q; k++) begin
      side_sr[k] <= side_sr[k-1];
    end
  end

  rgbc_div #(.NW(13), .DW(7), .QW(DIV_Q)) u_div_hue (
    .clk(clk), .num(hnum), .den(hden), .quo(hq)
  );
  rgbc_div #(.NW(14), .DW(8), .QW(DIV_Q)) u_div_sat (
    .clk(clk), .num(snum), .den(sden), .quo(sq)
  );

  // final selection of the result fields
  always_comb begin
    hue_next   = side_sr[DIV_Q-1].neg ? side_sr[DIV_Q-1].base - 9'(hq)
                                      : side_sr[DIV_Q-1].base + 9'(hq);
    sat_next   = sq;
    light_next = side_sr[DIV_Q-1].light;
    if (side_sr[DIV_Q-1].gray) begin
      hue_next = '0;
      sat_next = '0;
    end
    if (zc[LATENCY-2]) begin
      hue_next   = '0;
      sat_next   = '0;
      light_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    hue        <= hue_next;
    saturation <= sat_next;
    lightness  <= light_next;
    zero_clear <= zc[LATENCY-2];
  end

endmodule

`default_nettype wire

[rtl/rgbc_div.sv]
// pipelined restoring divider, one quotient bit per stage
// uses rgbc_pkg; requires num < den * 2**QW
`default_nettype none

module rgbc_div
  import rgbc_pkg::*;
#(
  parameter int NW = 23,
  parameter int DW = 16,
  parameter int QW = 7
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  localparam int W = (NW > DW + QW) ? NW : DW + QW;

  logic [W-1:0]  rem_in  [QW];
  logic [DW-1:0] den_in  [QW];
  logic [QW-1:0] quo_in  [QW];
  logic [W-1:0]  rem_next[QW];
  logic [QW-1:0] quo_next[QW];
  logic [W-1:0]  rem     [QW];
  logic [DW-1:0] dens    [QW];
  logic [QW-1:0] quos    [QW];

  // stage inputs come from the ports or the previous stage
  always_comb begin
    rem_in[0] = W'(num);
    den_in[0] = den;
    quo_in[0] = '0;
    for (int k = 1; k < QW; k++) begin
      rem_in[k] = rem[k-1];
      den_in[k] = dens[k-1];
      quo_in[k] = quos[k-1];
    end
  end

  // one trial subtraction per stage, most significant bit first
  always_comb begin
    for (int k = 0; k < QW; k++) begin
      quo_next[k] = quo_in[k];
      rem_next[k] = rem_in[k];
      if (rem_in[k] >= (W'(den_in[k]) << (QW - 1 - k))) begin
        rem_next[k] = rem_in[k] - (W'(den_in[k]) << (QW - 1 - k));
        quo_next[k][QW-1-k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QW; k++) begin
      rem[k]  <= rem_next[k];
      dens[k] <= den_in[k];
      quos[k] <= quo_next[k];
    end
  end

  assign quo = quos[QW-1];

endmodule

`default_nettype wire

[rtl/rgbc_chk.sv]
// port-level checker for the rgbc to hsl converter, bound to the top level
// uses rgbc_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module rgbc_chk
  import rgbc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [8:0] hue,
  input logic [6:0] saturation,
  input logic [6:0] lightness,
  input logic       zero_clear
);

  // every result traces back to an accepted transaction, as far back as the valid pipeline is deep
  `CHK_IMPLY(a_done_latency, clk, rst, done, $past(start && !busy, LATENCY), "orphan result")
  // result fields stay in range
  `CHK_IMPLY(a_range, clk, rst, done, hue <= HUE_WRAP && saturation <= PCT_FULL && lightness <= PCT_FULL, "result out of range")
  // zero clear count gives all-zero fields
  `CHK_IMPLY(a_zero, clk, rst, done && zero_clear, hue == '0 && saturation == '0 && lightness == '0, "zero clear not zeroed")
  // the converter takes a transaction in every cycle
  `CHK_ALWAYS(a_no_busy, clk, rst, !busy, "busy raised")

endmodule

bind rgbc_to_hsl_converter rgbc_chk u_rgbc_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .hue(hue), .saturation(saturation), .lightness(lightness), .zero_clear(zero_clear)
);

`default_nettype wire

[dv/tb_rgbc_to_hsl_converter.sv]
// self-checking testbench of the rgbc to hsl converter
// depends on rgbc_pkg and rgbc_to_hsl_converter; a table of directed
// transactions is followed by random ones, checked against typed results or a predictor
`timescale 1ns / 1ps

module tb_rgbc_to_hsl_converter;
  import rgbc_pkg::*;

  localparam int N_RANDOM = 630;

  typedef struct packed {
    logic [15:0] clr;
    logic [15:0] red;
    logic [15:0] grn;
    logic [15:0] blu;
  } rgbc_t;

  typedef struct packed {
    logic [8:0] h;
    logic [6:0] s;
    logic [6:0] l;
    logic       zc;
  } hsl_t;

  // directed row: counts, whether a typed result applies, and that result
  typedef struct packed {
    rgbc_t stim;
    logic  typed;
    hsl_t  want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [15:0] clear_count = '0;
  logic [15:0] red_count = '0;
  logic [15:0] green_count = '0;
  logic [15:0] blue_count = '0;
  logic        busy;
  logic        done;
  logic [8:0]  hue;
  logic [6:0]  saturation;
  logic [6:0]  lightness;
  logic        zero_clear;

  hsl_t hsl_pending[$];
  int   n_errors = 0;

  always #1 clk = ~clk;

  rgbc_to_hsl_converter #(.COUNT_BITS(16)) u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .clear_count(clear_count), .red_count(red_count),
    .green_count(green_count), .blue_count(blue_count),
    .done(done), .hue(hue), .saturation(saturation),
    .lightness(lightness), .zero_clear(zero_clear)
  );

  // percentage of clear, saturated at full scale
  function automatic int unsigned to_pct(logic [15:0] cnt, logic [15:0] clr);
    longint unsigned q;
    q = (longint'(cnt) * 100) / longint'(clr);
    return (q > 100) ? 100 : int'(q);
  endfunction

  // sector base plus or minus truncated 60*delta/dif
  function automatic int unsigned hue_of(int unsigned base, int unsigned a,
                                         int unsigned b, int unsigned dif);
    if (a >= b) return base + (60 * (a - b)) / dif;
    return base - (60 * (b - a)) / dif;
  endfunction

  function automatic hsl_t hsl_of(rgbc_t t);
    int unsigned r, g, b, mx, mn, dif, sum, h, s;
    hsl_t o;
    o = '0;
    if (t.clr == 0) begin
      o.zc = 1'b1;
      return o;
    end
    r = to_pct(t.red, t.clr);
    g = to_pct(t.grn, t.clr);
    b = to_pct(t.blu, t.clr);
    mx = r; if (g > mx) mx = g; if (b > mx) mx = b;
    mn = r; if (g < mn) mn = g; if (b < mn) mn = b;
    dif = mx - mn;
    sum = mx + mn;
    h = 0;
    s = 0;
    if (dif != 0) begin
      if (mx == r) h = hue_of((g >= b) ? 0 : 360, g, b, dif);
      else if (mx == g) h = hue_of(120, b, r, dif);
      else h = hue_of(240, r, g, dif);
      s = (sum / 2 <= 50) ? (dif * 100) / sum : (dif * 100) / (200 - sum);
    end
    o.h = h[8:0];
    o.s = s[6:0];
    o.l = 7'(sum / 2);
    return o;
  endfunction

  // one transaction: start drops only over a gap, then held until accepted
  task automatic send(rgbc_t t, hsl_t want, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    clear_count <= t.clr;
    red_count <= t.red;
    green_count <= t.grn;
    blue_count <= t.blu;
    @(posedge clk);
    while (busy) @(posedge clk);
    hsl_pending.push_back(want);
  endtask

  function automatic logic [15:0] rand_count();
    case ($urandom_range(0, 5))
      0: return 16'(($urandom_range(0, 1)) ? 16'hffff : 16'h0000);
      1: return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  // result checker; done only marks a cycle, there is no backpressure
  always @(posedge clk) begin
    hsl_t w;
    if (!rst && done) begin
      if (hsl_pending.size() == 0) begin
        $display("%0t: unexpected result h=%0d s=%0d l=%0d z=%0b", $time,
                 hue, saturation, lightness, zero_clear);
        n_errors++;
      end else begin
        w = hsl_pending.pop_front();
        if (hue !== w.h) begin
          $display("%0t: hue expected %0d actual %0d", $time, w.h, hue);
          n_errors++;
        end
        if (saturation !== w.s) begin
          $display("%0t: saturation expected %0d actual %0d", $time, w.s, saturation);
          n_errors++;
        end
        if (lightness !== w.l) begin
          $display("%0t: lightness expected %0d actual %0d", $time, w.l, lightness);
          n_errors++;
        end
        if (zero_clear !== w.zc) begin
          $display("%0t: zero_clear expected %0b actual %0b", $time, w.zc, zero_clear);
          n_errors++;
        end
      end
    end
  end

  initial begin
    #200000;
    $display("tb_rgbc_to_hsl_converter: errors");
    $finish;
  end

  initial begin
    row_t  rows[$];
    rgbc_t t;
    hsl_t  w;
    int    waited;
    // counts clr/red/grn/blu, typed flag, typed h/s/l/zero_clear
    rows = '{
      '{'{16'd0, 16'd0, 16'd0, 16'd0}, 1'b1, '{9'd0, 7'd0, 7'd0, 1'b1}},
      '{'{16'd0, 16'hffff, 16'hffff, 16'hffff}, 1'b1, '{9'd0, 7'd0, 7'd0, 1'b1}},
      '{'{16'hffff, 16'hffff, 16'hffff, 16'hffff}, 1'b1, '{9'd0, 7'd0, 7'd100, 1'b0}},
      '{'{16'hffff, 16'd0, 16'd0, 16'd0}, 1'b1, '{9'd0, 7'd0, 7'd0, 1'b0}},
      '{'{16'd1, 16'hffff, 16'd0, 16'd0}, 1'b1, '{9'd0, 7'd100, 7'd50, 1'b0}},
      '{'{16'd1, 16'd0, 16'hffff, 16'd0}, 1'b1, '{9'd120, 7'd100, 7'd50, 1'b0}},
      '{'{16'd1, 16'd0, 16'd0, 16'hffff}, 1'b1, '{9'd240, 7'd100, 7'd50, 1'b0}},
      '{'{16'd100, 16'd100, 16'd100, 16'd0}, 1'b1, '{9'd60, 7'd100, 7'd50, 1'b0}},
      '{'{16'd100, 16'd100, 16'd0, 16'd100}, 1'b1, '{9'd300, 7'd100, 7'd50, 1'b0}},
      '{'{16'd100, 16'd0, 16'd100, 16'd100}, 1'b1, '{9'd180, 7'd100, 7'd50, 1'b0}},
      '{'{16'd100, 16'd50, 16'd50, 16'd50}, 1'b1, '{9'd0, 7'd0, 7'd50, 1'b0}},
      // red max with blue just above green: hue wraps to 360
      '{'{16'd100, 16'd100, 16'd0, 16'd1}, 1'b0, '0},
      '{'{16'd1000, 16'd999, 16'd1, 16'd2}, 1'b0, '0},
      '{'{16'd100, 16'd80, 16'd60, 16'd20}, 1'b0, '0},
      '{'{16'd100, 16'd90, 16'd85, 16'd70}, 1'b0, '0},
      '{'{16'd100, 16'd30, 16'd20, 16'd10}, 1'b0, '0},
      '{'{16'd100, 16'd40, 16'd60, 16'd50}, 1'b0, '0},
      '{'{16'd100, 16'd20, 16'd10, 16'd90}, 1'b0, '0},
      '{'{16'd7, 16'd3, 16'd900, 16'd5}, 1'b0, '0},
      '{'{16'h8000, 16'h7fff, 16'h5555, 16'haaaa}, 1'b0, '0},
      '{'{16'd1, 16'd0, 16'd0, 16'd1}, 1'b0, '0}
    };
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (rows[i]) begin
      w = rows[i].typed ? rows[i].want : hsl_of(rows[i].stim);
      send(rows[i].stim, w, (i < 10) ? 0 : $urandom_range(0, 5));
    end

    // random part, with idle-free stretches and one full drain
    for (int k = 0; k < N_RANDOM; k++) begin
      t.clr = ($urandom_range(0, 19) == 0) ? 16'd0 : rand_count();
      t.red = rand_count();
      t.grn = rand_count();
      t.blu = rand_count();
      if (k == N_RANDOM / 2) begin
        start <= 1'b0;
        waited = 0;
        while (hsl_pending.size() != 0 && waited < 1000) begin
          @(posedge clk);
          waited++;
        end
      end
      send(t, hsl_of(t), ((k / 50) % 3 == 0) ? 0 : $urandom_range(0, 5));
    end

    start <= 1'b0;
    waited = 0;
    while (hsl_pending.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 5) @(posedge clk);
    if (n_errors == 0 && hsl_pending.size() == 0) begin
      $display("tb_rgbc_to_hsl_converter: clean");
    end else begin
      $display("tb_rgbc_to_hsl_converter: errors");
    end
    $finish;
  end

endmodule
